[src/fwlc_pkg.sv]
// Shared definitions for the wear-leveled flash counter: field widths,
// command codes, level thresholds and the item/result structs.
// No dependencies.
`default_nettype none

package fwlc_pkg;

  // Fixed field widths of the item and result ports
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 12;
  localparam int DATA_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int PAGE_IDX_W = 4;
  localparam int BYTE_IDX_W = 8;
  localparam int LEVEL_W    = 4;

  // Default geometry of the counter sector
  localparam int unsigned DEF_PAGES_PER_SECTOR = 16;
  localparam int unsigned DEF_BYTES_PER_PAGE   = 256;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INC        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN_START = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN_BYTE  = 2'd3;

  // Byte values
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;
  localparam logic [DATA_W-1:0] FRESH_BYTE  = 8'h7F;

  // Level thresholds: value above THR_Lk gives level k
  localparam logic [DATA_W-1:0] THR_L1 = 8'h7E;
  localparam logic [DATA_W-1:0] THR_L2 = 8'h3E;
  localparam logic [DATA_W-1:0] THR_L3 = 8'h1E;
  localparam logic [DATA_W-1:0] THR_L4 = 8'h0E;
  localparam logic [DATA_W-1:0] THR_L5 = 8'h06;
  localparam logic [DATA_W-1:0] THR_L6 = 8'h02;
  localparam logic [DATA_W-1:0] THR_L7 = 8'h00;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] scan_address;
    logic [DATA_W-1:0] flash_byte;
  } fwlc_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]    count;
    logic                  erase_sector;
    logic                  program_page;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [DATA_W-1:0]     byte_value;
  } fwlc_result_t;

  // Level code 1..8 of the current byte, from its number of cleared bits
  function automatic logic [LEVEL_W-1:0] level_of(input logic [DATA_W-1:0] v);
    logic [LEVEL_W-1:0] lvl;
    if (v > THR_L1)      lvl = 4'd1;
    else if (v > THR_L2) lvl = 4'd2;
    else if (v > THR_L3) lvl = 4'd3;
    else if (v > THR_L4) lvl = 4'd4;
    else if (v > THR_L5) lvl = 4'd5;
    else if (v > THR_L6) lvl = 4'd6;
    else if (v > THR_L7) lvl = 4'd7;
    else                 lvl = 4'd8;
    return lvl;
  endfunction

endpackage

`default_nettype wire

[src/flash_wear_leveled_counter_unit.sv]
// Top level of the wear-leveled flash counter: input register, position
// update core and result register with the valid/stall handshake.
// Depends on fwlc_pkg and fwlc_core.
`default_nettype none

// Wear-leveled unary counter for one flash sector. Each item is a command:
// increment, reset-and-erase, start scan, or scan one flash byte with its
// address. Every item returns exactly one result with the count (page,
// byte and level of the current byte), the current page, byte index and
// byte value, plus erase and program requests for the flash driver.
// The block takes one item per clock cycle while the output is not stalled.
// An accepted item lands in an input register; the position update then runs
// in one pass and writes the result register, from which the result is taken
// when the output is not stalled. The position registers are written in the
// same cycle as the result register, which is what lets the next item follow
// directly. A stalled result backs up into the input register; both hold
// until the output drains.
module flash_wear_leveled_counter_unit #(
  parameter int unsigned PAGES_PER_SECTOR = fwlc_pkg::DEF_PAGES_PER_SECTOR,
  parameter int unsigned BYTES_PER_PAGE   = fwlc_pkg::DEF_BYTES_PER_PAGE
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Command item channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [fwlc_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [fwlc_pkg::ADDR_W-1:0]       in_scan_address,
  input  wire logic [fwlc_pkg::DATA_W-1:0]       in_flash_byte,
  // Result item channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [fwlc_pkg::COUNT_W-1:0]           out_count,
  output logic                                   out_erase_sector,
  output logic                                   out_program_page,
  output logic [fwlc_pkg::PAGE_IDX_W-1:0]        out_page_index,
  output logic [fwlc_pkg::BYTE_IDX_W-1:0]        out_byte_index,
  output logic [fwlc_pkg::DATA_W-1:0]            out_byte_value
);

  logic                   in_valid_r;
  fwlc_pkg::fwlc_item_t   item_r;
  logic                   out_valid_r;
  fwlc_pkg::fwlc_result_t result_r;
  fwlc_pkg::fwlc_result_t result_nxt;
  logic                   step;

  // Advance the held item when the result register is empty or draining
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  // Hold the input side only while a held item cannot advance
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.cmd          <= in_cmd;
      item_r.scan_address <= in_scan_address;
      item_r.flash_byte   <= in_flash_byte;
    end
  end

  fwlc_core #(
    .PAGES_PER_SECTOR (PAGES_PER_SECTOR),
    .BYTES_PER_PAGE   (BYTES_PER_PAGE)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .result (result_nxt)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_count        = result_r.count;
  assign out_erase_sector = result_r.erase_sector;
  assign out_program_page = result_r.program_page;
  assign out_page_index   = result_r.page_index;
  assign out_byte_index   = result_r.byte_index;
  assign out_byte_value   = result_r.byte_value;

  // An accepted item always reaches the input register
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_valid_r)
    else $error("accepted item missing from input register");

  // An increment never leaves the current byte fully erased
  a_inc_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_program_page) |-> (out_byte_value != fwlc_pkg::ERASED_BYTE))
    else $error("increment result reports erased byte");

  // A reset command result is the home position, count one
  a_reset_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_erase_sector && !out_program_page)
      |-> (out_count == 16'd1 && out_page_index == '0 && out_byte_index == '0))
    else $error("reset command result not at home position");

endmodule

`default_nettype wire

[src/fwlc_core.sv]
// Position registers of the wear-leveled counter and the single-pass update
// that turns one item into the next position and its result.
// Depends on fwlc_pkg.
`default_nettype none

module fwlc_core #(
  parameter int unsigned PAGES_PER_SECTOR = fwlc_pkg::DEF_PAGES_PER_SECTOR,
  parameter int unsigned BYTES_PER_PAGE   = fwlc_pkg::DEF_BYTES_PER_PAGE
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire fwlc_pkg::fwlc_item_t item,
  output fwlc_pkg::fwlc_result_t    result
);

  localparam int ADDR_W  = fwlc_pkg::ADDR_W;
  localparam int DATA_W  = fwlc_pkg::DATA_W;
  localparam int COUNT_W = fwlc_pkg::COUNT_W;
  localparam int PAGE_W  = $clog2(PAGES_PER_SECTOR);
  localparam int BYTE_W  = $clog2(BYTES_PER_PAGE);

  localparam int PAGE_IDX_PAD = fwlc_pkg::PAGE_IDX_W;
  localparam int BYTE_IDX_PAD = fwlc_pkg::BYTE_IDX_W;

  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES_PER_SECTOR - 1);
  localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(BYTES_PER_PAGE - 1);

  // Address split by reciprocal multiply; exact for every ADDR_W-bit address
  localparam int RECIP_SHIFT        = ADDR_W + BYTE_W;
  localparam int unsigned RECIP     = ((1 << RECIP_SHIFT) + BYTES_PER_PAGE - 1)
                                      / BYTES_PER_PAGE;
  localparam int RECIP_W            = RECIP_SHIFT - 3;
  localparam int PROD_W             = ADDR_W + RECIP_W;
  localparam int QUOT_W             = ADDR_W - BYTE_W + 1;
  localparam int PAGE_TERM_W        = PAGE_W + COUNT_W;

  logic [PAGE_W-1:0] cur_page_r,  cur_page_nxt;
  logic [BYTE_W-1:0] cur_byte_r,  cur_byte_nxt;
  logic [DATA_W-1:0] cur_value_r, cur_value_nxt;
  logic [ADDR_W-1:0] found_addr_r, found_addr_nxt;

  logic                      erase_flag;
  logic                      program_flag;
  logic [PROD_W-1:0]         scan_prod;
  logic [QUOT_W-1:0]         scan_page;
  logic [QUOT_W+PAGE_W-1:0]  scan_page_ext;
  logic [ADDR_W-1:0]         scan_offset;
  logic                      scan_hit;
  logic [PAGE_TERM_W-1:0]    page_term;
  logic [COUNT_W-1:0]        byte_term;
  logic [PAGE_W+PAGE_IDX_PAD-1:0] page_ext;
  logic [BYTE_W+BYTE_IDX_PAD-1:0] byte_ext;

  // Page and offset of the scanned address
  always_comb begin
    scan_prod     = PROD_W'(item.scan_address) * PROD_W'(RECIP);
    scan_page     = scan_prod[RECIP_SHIFT +: QUOT_W];
    scan_page_ext = {{PAGE_W{1'b0}}, scan_page};
    scan_offset   = item.scan_address
                    - ADDR_W'(ADDR_W'(scan_page) * ADDR_W'(BYTES_PER_PAGE));
    scan_hit      = (item.flash_byte != fwlc_pkg::ERASED_BYTE)
                    && (32'(scan_page) < 32'(PAGES_PER_SECTOR))
                    && (item.scan_address >= found_addr_r);
  end

  always_comb begin
    cur_page_nxt   = cur_page_r;
    cur_byte_nxt   = cur_byte_r;
    cur_value_nxt  = cur_value_r;
    found_addr_nxt = found_addr_r;
    erase_flag     = 1'b0;
    program_flag   = 1'b0;
    unique case (item.cmd) inside
      fwlc_pkg::CMD_INC: begin
        program_flag = 1'b1;
        if (cur_value_r != '0) begin
          cur_value_nxt = cur_value_r >> 1;
        end else if (cur_byte_r != LAST_BYTE) begin
          cur_byte_nxt  = cur_byte_r + 1'b1;
          cur_value_nxt = fwlc_pkg::FRESH_BYTE;
        end else if (cur_page_r != LAST_PAGE) begin
          cur_page_nxt  = cur_page_r + 1'b1;
          cur_byte_nxt  = '0;
          cur_value_nxt = fwlc_pkg::FRESH_BYTE;
        end else begin
          erase_flag    = 1'b1;
          cur_page_nxt  = '0;
          cur_byte_nxt  = '0;
          cur_value_nxt = fwlc_pkg::FRESH_BYTE;
        end
      end
      fwlc_pkg::CMD_RESET, fwlc_pkg::CMD_SCAN_START: begin
        erase_flag     = (item.cmd == fwlc_pkg::CMD_RESET);
        cur_page_nxt   = '0;
        cur_byte_nxt   = '0;
        cur_value_nxt  = fwlc_pkg::ERASED_BYTE;
        found_addr_nxt = '0;
      end
      fwlc_pkg::CMD_SCAN_BYTE: begin
        if (scan_hit) begin
          found_addr_nxt = item.scan_address;
          cur_page_nxt   = scan_page_ext[PAGE_W-1:0];
          cur_byte_nxt   = scan_offset[BYTE_W-1:0];
          cur_value_nxt  = item.flash_byte;
        end
      end
    endcase
  end

  // Result reports the position after the item
  always_comb begin
    page_term = PAGE_TERM_W'(cur_page_nxt) * PAGE_TERM_W'(BYTES_PER_PAGE * 8);
    byte_term = COUNT_W'({cur_byte_nxt, 3'b000});
    page_ext  = {{PAGE_IDX_PAD{1'b0}}, cur_page_nxt};
    byte_ext  = {{BYTE_IDX_PAD{1'b0}}, cur_byte_nxt};
    result.count        = page_term[COUNT_W-1:0] + byte_term
                          + COUNT_W'(fwlc_pkg::level_of(cur_value_nxt));
    result.erase_sector = erase_flag;
    result.program_page = program_flag;
    result.page_index   = page_ext[PAGE_IDX_PAD-1:0];
    result.byte_index   = byte_ext[BYTE_IDX_PAD-1:0];
    result.byte_value   = cur_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_page_r   <= '0;
      cur_byte_r   <= '0;
      cur_value_r  <= fwlc_pkg::ERASED_BYTE;
      found_addr_r <= '0;
    end else if (step) begin
      cur_page_r   <= cur_page_nxt;
      cur_byte_r   <= cur_byte_nxt;
      cur_value_r  <= cur_value_nxt;
      found_addr_r <= found_addr_nxt;
    end
  end

endmodule

`default_nettype wire
